// ===== hdl/julian_day_to_date_top_macros.svh =====
// Assertion macros for the Julian day number to date converter.
// Used by julian_day_to_date_top; expects clk and rst_n in scope.
`ifndef JULIAN_DAY_TO_DATE_TOP_MACROS_SVH
`define JULIAN_DAY_TO_DATE_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define JDD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define JDD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/jdd_pkg.sv =====
// Shared types and constants for the Julian day number to date converter.
// No dependencies.
package jdd_pkg;

  localparam int JDW = 23;  // day number width
  localparam int YW  = 16;  // internal year width, signed
  localparam int TW  = 10;  // day-of-year offset width

  // Offsets that make the year-estimate numerator non-negative:
  // jd - 1721120 + 12*146097 and jd - 1721118 + 1179*1461.
  localparam logic [23:0] GREG_ADD  = 24'(12 * 146097 - 1721120);
  localparam logic [23:0] JUL_ADD   = 24'(1179 * 1461 - 1721118);
  localparam logic [15:0] GREG_BIAS = 16'(12 * 400);
  localparam logic [15:0] JUL_BIAS  = 16'(1179 * 4);

  // Year estimate q = floor(NUM * x / DIV), x < 2^24.
  localparam int          RECIP_SH   = 24;
  localparam logic [8:0]  GREG_NUM   = 9'd400;
  localparam logic [8:0]  JUL_NUM    = 9'd4;
  localparam logic [17:0] GREG_DIV   = 18'd146097;
  localparam logic [17:0] JUL_DIV    = 18'd1461;
  localparam logic [15:0] GREG_RECIP = 16'(((64'd1 << RECIP_SH) * 64'd400) / 64'd146097);
  localparam logic [15:0] JUL_RECIP  = 16'(((64'd1 << RECIP_SH) * 64'd4) / 64'd1461);

  // floor(n / 100) for n < 2^15, exact with a rounded-up reciprocal.
  localparam int          CENT_SH    = 21;
  localparam logic [14:0] CENT_RECIP = 15'(((64'd1 << CENT_SH) + 64'd99) / 64'd100);

  // Year start base and days-per-year factor.
  localparam logic signed [25:0] YEAR_BASE = 26'sd1720995;
  localparam logic signed [27:0] DAYS_4Y   = 28'sd1461;

  // Month index floor(10000 t / 306001) for t < 2^10, exact.
  localparam int          MON_SH    = 29;
  localparam logic [24:0] MON_RECIP =
    25'((((64'd1 << MON_SH) * 64'd10000) + 64'd306000) / 64'd306001);

  // floor(3 m / 5) as (m * 3 * 205) >> 10 for m < 64.
  localparam logic [15:0] FIFTH3_MUL = 16'd615;
  localparam int          FIFTH_SH   = 10;

  localparam logic signed [16:0] YEAR_MIN = -17'sd4714;
  localparam logic signed [16:0] YEAR_MAX = 17'sd9999;

  typedef struct packed {
    logic           vld;
    logic           greg;
    logic [JDW-1:0] jd;
  } ctl_t;

endpackage

// ===== hdl/jdd_year_est.sv =====
// Year estimate: four pipeline stages, reciprocal multiply plus one correction.
// Depends on jdd_pkg.
module jdd_year_est import jdd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  ctl_t                 ctl_i,
  output ctl_t                 ctl_o,
  output logic signed [YW-1:0] year_o
);

  logic [3:0]     vld_r;
  logic [3:0]     greg_r;
  logic [JDW-1:0] jd_r [4];

  logic [23:0] x1_r, x2_r;
  logic [15:0] q0_r, q3_r;
  logic [33:0] qd_r, ax_r;
  logic signed [YW-1:0] y_r;

  logic [23:0] x1_nxt;
  logic [39:0] prod2;
  logic [15:0] q0_nxt;
  logic [33:0] qd_nxt, ax_nxt, r4;
  logic [15:0] qc;
  logic signed [YW:0] y_wide;
  logic signed [YW-1:0] y_nxt;

  always_comb begin
    x1_nxt = {1'b0, ctl_i.jd} + (ctl_i.greg ? GREG_ADD : JUL_ADD);
    prod2  = 40'(x1_r) * 40'(greg_r[0] ? GREG_RECIP : JUL_RECIP);
    q0_nxt = prod2[39:RECIP_SH];
    qd_nxt = 34'(q0_r) * 34'(greg_r[1] ? GREG_DIV : JUL_DIV);
    ax_nxt = 34'(x2_r) * 34'(greg_r[1] ? GREG_NUM : JUL_NUM);
    // estimate is low by at most one
    r4     = ax_r - qd_r;
    qc     = q3_r + 16'(r4 >= 34'(greg_r[2] ? GREG_DIV : JUL_DIV));
    y_wide = $signed({1'b0, qc}) - $signed({1'b0, greg_r[2] ? GREG_BIAS : JUL_BIAS});
    y_nxt  = y_wide[YW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], ctl_i.vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      greg_r  <= {greg_r[2:0], ctl_i.greg};
      jd_r[0] <= ctl_i.jd;
      jd_r[1] <= jd_r[0];
      jd_r[2] <= jd_r[1];
      jd_r[3] <= jd_r[2];
      x1_r    <= x1_nxt;
      x2_r    <= x1_r;
      q0_r    <= q0_nxt;
      q3_r    <= q0_r;
      qd_r    <= qd_nxt;
      ax_r    <= ax_nxt;
      y_r     <= y_nxt;
    end
  end

  assign ctl_o  = '{vld: vld_r[3], greg: greg_r[3], jd: jd_r[3]};
  assign year_o = y_r;

endmodule

// ===== hdl/jdd_year_start.sv =====
// Year start day and day-of-year offset: three pipeline stages.
// Depends on jdd_pkg.
module jdd_year_start import jdd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  ctl_t                 ctl_i,
  input  logic signed [YW-1:0] year_i,
  output logic                 vld_o,
  output logic signed [YW-1:0] year_o,
  output logic [TW-1:0]        t_o,
  output logic                 t_ok_o
);

  logic [2:0]           vld_r;
  logic                 greg_r;
  logic [JDW-1:0]       jd_r [2];
  logic signed [YW-1:0] y_r [3];

  logic signed [27:0] b5_r;
  logic [8:0]         c5_r;
  logic               neg5_r;
  logic signed [25:0] s6_r;
  logic [TW-1:0]      t7_r;
  logic               tok7_r;

  logic signed [27:0] b_nxt;
  logic [YW-1:0]      ay_full;
  logic [29:0]        cp;
  logic [8:0]         c4, k;
  logic signed [10:0] corr;
  logic signed [25:0] s_nxt;
  logic signed [25:0] t_full;

  always_comb begin
    b_nxt   = 28'(year_i) * DAYS_4Y;
    ay_full = year_i[YW-1] ? YW'(-year_i) : YW'(year_i);
    cp      = 30'(ay_full[14:0]) * 30'(CENT_RECIP);
    // century correction truncates toward zero: work on |y|, y/400 = (y/100)/4
    c4      = c5_r >> 2;
    k       = c5_r - c4;
    if (!greg_r) begin
      corr = '0;
    end else if (neg5_r) begin
      corr = 11'sd2 + $signed({2'b0, k});
    end else begin
      corr = 11'sd2 - $signed({2'b0, k});
    end
    s_nxt  = YEAR_BASE + 26'(b5_r >>> 2) + 26'(corr);
    t_full = $signed({3'b0, jd_r[1]}) - s6_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[1:0], ctl_i.vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      greg_r  <= ctl_i.greg;
      jd_r[0] <= ctl_i.jd;
      jd_r[1] <= jd_r[0];
      y_r[0]  <= year_i;
      y_r[1]  <= y_r[0];
      y_r[2]  <= y_r[1];
      b5_r    <= b_nxt;
      c5_r    <= cp[29:CENT_SH];
      neg5_r  <= year_i[YW-1];
      s6_r    <= s_nxt;
      t7_r    <= t_full[TW-1:0];
      tok7_r  <= !t_full[25] && (t_full[25:TW] == '0);
    end
  end

  assign vld_o  = vld_r[2];
  assign year_o = y_r[2];
  assign t_o    = t7_r;
  assign t_ok_o = tok7_r;

endmodule

// ===== hdl/jdd_date_split.sv =====
// Month and day split, calendar fix-ups and range check: two stages.
// The second stage is the output register. Depends on jdd_pkg.
module jdd_date_split import jdd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 vld_i,
  input  logic signed [YW-1:0] year_i,
  input  logic [TW-1:0]        t_i,
  input  logic                 t_ok_i,
  output logic                 vld_o,
  output logic [4:0]           day_o,
  output logic [3:0]           month_o,
  output logic signed [14:0]   year_o,
  output logic                 err_o
);

  logic [1:0]           vld_r;
  logic [5:0]           m8_r;
  logic [TW-1:0]        t8_r;
  logic                 tok8_r;
  logic signed [YW-1:0] y8_r;

  logic [4:0]         day_r;
  logic [3:0]         month_r;
  logic signed [14:0] year_r;
  logic               err_r;

  logic [34:0]        mp;
  logic [15:0]        m3;
  logic [10:0]        fm;
  logic signed [11:0] d_s;
  logic signed [6:0]  mm0, mm;
  logic signed [16:0] yy0, yy;
  logic               bad;

  always_comb begin
    mp  = 35'(t_i) * 35'(MON_RECIP);
    // floor(30.6001 m) = 30 m + floor(3 m / 5) for small m
    m3  = 16'(m8_r) * FIFTH3_MUL;
    fm  = 11'(m8_r) * 11'd30 + 11'(m3[15:FIFTH_SH]);
    d_s = $signed({2'b0, t8_r}) - $signed({1'b0, fm});
    mm0 = $signed({1'b0, m8_r}) - 7'sd1;
    mm  = (mm0 > 7'sd12) ? mm0 - 7'sd12 : mm0;
    yy0 = 17'(y8_r) + ((mm <= 7'sd2) ? 17'sd1 : 17'sd0);
    // no year zero
    yy  = (yy0 <= 17'sd0) ? yy0 - 17'sd1 : yy0;
    bad = !tok8_r || (yy < YEAR_MIN) || (yy > YEAR_MAX) ||
          (mm < 7'sd1) || (mm > 7'sd12) || (d_s < 12'sd1) || (d_s > 12'sd31);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m8_r    <= mp[34:MON_SH];
      t8_r    <= t_i;
      tok8_r  <= t_ok_i;
      y8_r    <= year_i;
      day_r   <= bad ? '0 : d_s[4:0];
      month_r <= bad ? '0 : mm[3:0];
      year_r  <= bad ? '0 : yy[14:0];
      err_r   <= bad;
    end
  end

  assign vld_o   = vld_r[1];
  assign day_o   = day_r;
  assign month_o = month_r;
  assign year_o  = year_r;
  assign err_o   = err_r;

endmodule

// ===== hdl/julian_day_to_date_top.sv =====
// Julian day number to calendar date converter, top level.
// Depends on jdd_pkg, jdd_year_est, jdd_year_start, jdd_date_split and
// julian_day_to_date_top_macros.svh.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-----------------------------------
//  in_     | request   | in_valid / in_ready   | in_day_number
//  out_    | result    | out_valid / out_ready | day, month, year, range_error
//  cfg_    | write     | cfg_valid / cfg_ready | cfg_calendar_switch_day
//
// One request per cycle while no result is held at the output; each result
// passes 4 stages of year estimate, 3 of year start and 2 of month/day split.
// The output register is the last stage. While a result waits there, every
// stage holds and in_ready drops in the same cycle, so nothing is lost or
// repeated. Synchronous active-low reset clears the valid bits and loads the
// switch day 2361222; cfg_ready is always high.
`include "julian_day_to_date_top_macros.svh"

module julian_day_to_date_top import jdd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [22:0]          in_day_number,

  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [4:0]           out_day_of_month,
  output logic [3:0]           out_month_of_year,
  output logic signed [14:0]   out_year_value,
  output logic                 out_range_error,

  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [22:0]          cfg_calendar_switch_day
);

  // Calendar switch register; first day number with Gregorian rules.
  logic [JDW-1:0] switch_day_r;

  // Global advance: the whole pipe moves unless a result is stuck at the end.
  logic en;

  ctl_t                 in_ctl, est_ctl;
  logic signed [YW-1:0] est_year, st_year;
  logic                 st_vld;
  logic [TW-1:0]        st_t;
  logic                 st_t_ok;

  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      switch_day_r <= 23'd2361222;
    end else if (cfg_valid) begin
      switch_day_r <= cfg_calendar_switch_day;
    end
  end

  // Calendar rule is picked once at entry and rides along with the request.
  assign in_ctl = '{vld: in_valid,
                    greg: in_day_number >= switch_day_r,
                    jd: in_day_number};

  // Year estimate from the day number (reciprocal multiply, one fix-up).
  jdd_year_est u_year_est (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .ctl_i  (in_ctl),
    .ctl_o  (est_ctl),
    .year_o (est_year)
  );

  // Start day of the March-based year and offset of the day within it.
  jdd_year_start u_year_start (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .ctl_i  (est_ctl),
    .year_i (est_year),
    .vld_o  (st_vld),
    .year_o (st_year),
    .t_o    (st_t),
    .t_ok_o (st_t_ok)
  );

  // Month and day, January/February roll into the next year, range check.
  jdd_date_split u_date_split (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_i   (st_vld),
    .year_i  (st_year),
    .t_i     (st_t),
    .t_ok_i  (st_t_ok),
    .vld_o   (out_valid),
    .day_o   (out_day_of_month),
    .month_o (out_month_of_year),
    .year_o  (out_year_value),
    .err_o   (out_range_error)
  );

  // A good date has legal day and month and never year zero.
  `JDD_ASSERT_SAME(a_date_legal, out_valid && !out_range_error, (out_day_of_month != 5'd0) && (out_month_of_year != 4'd0) && (out_month_of_year <= 4'd12) && (out_year_value != 15'sd0), "legal date expected without range_error")
  // An error result carries zeros in every date field.
  `JDD_ASSERT_SAME(a_err_zero, out_valid && out_range_error, (out_day_of_month == 5'd0) && (out_month_of_year == 4'd0) && (out_year_value == 15'sd0), "range_error result must be zero")
  // Only a held result may stall the input side.
  `JDD_ASSERT_SAME(a_stall_cause, !in_ready, out_valid && !out_ready, "input stalled without output backpressure")
  // A config write lands in the switch register.
  `JDD_ASSERT_NEXT(a_cfg_write, cfg_valid, switch_day_r == $past(cfg_calendar_switch_day), "switch day write lost")

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for julian_day_to_date_top (day number to calendar date).
// Depends on jdd_pkg and the julian_day_to_date_top RTL; no other files.

module tb;

  localparam int CLK_PERIOD = 12;
  localparam int RST_CYCLES = 12;
  localparam int IDLE_LIMIT = 4000;  // cycles with no handshake at all before giving up
  localparam int DRAIN_WAIT = 20;    // pipeline is 9 deep; margin for stray results
  localparam int N_ROWS     = 24;
  localparam int N_PHASES   = 10;
  localparam int PHASE_REQS = 150;
  localparam int LONG_HOLD  = 300;   // receiver hold-off long enough to back up the pipe

  // Calendar constants, all exact integers.
  localparam longint GREG_EPOCH = 1721120;
  localparam longint JUL_EPOCH  = 1721118;
  localparam longint GREG_YEAR  = 3652425;  // 365.2425 * 10000
  localparam longint YEAR_BASE  = 1720995;
  localparam longint MONTH_LEN  = 306001;   // 30.6001 * 10000
  localparam longint YEAR_LO    = -4714;
  localparam longint YEAR_HI    = 9999;
  localparam logic [22:0] SWITCH_RESET = 23'd2361222;
  localparam logic [22:0] DAY_TOP      = 23'd5373484;  // 31 Dec 9999 Gregorian

  typedef logic [jdd_pkg::JDW-1:0] day_num_t;

  typedef struct packed {
    logic [4:0]         day;
    logic [3:0]         month;
    logic signed [14:0] year;
    logic               err;
  } date_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e kind;
    day_num_t  val;
    logic      typed;  // expected date written into the row, not predicted
    date_t     want;
  } row_t;

  localparam date_t NO_DATE  = '0;
  localparam date_t BAD_DATE = '{5'd0, 4'd0, 15'sd0, 1'b1};

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  day_num_t           in_day_number;
  logic               out_valid;
  logic               out_ready;
  logic [4:0]         out_day_of_month;
  logic [3:0]         out_month_of_year;
  logic signed [14:0] out_year_value;
  logic               out_range_error;
  logic               cfg_valid;
  logic               cfg_ready;
  day_num_t           cfg_calendar_switch_day;

  // Scoreboard state, updated only at the rising edge.
  date_t    dates_due [$];
  day_num_t switch_day = SWITCH_RESET;
  int       err_cnt    = 0;
  int       dates_seen = 0;
  int       idle_cycles = 0;
  bit       in_acc  = 0;   // handshake flags: set at posedge, read by drivers at negedge
  bit       cfg_acc = 0;

  // Directed rows carry their own expectation alongside the request payload.
  logic     row_typed;
  date_t    row_want;

  row_t     dir_tab [N_ROWS];

  julian_day_to_date_top dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_ready                (in_ready),
    .in_day_number           (in_day_number),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_day_of_month        (out_day_of_month),
    .out_month_of_year       (out_month_of_year),
    .out_year_value          (out_year_value),
    .out_range_error         (out_range_error),
    .cfg_valid               (cfg_valid),
    .cfg_ready               (cfg_ready),
    .cfg_calendar_switch_day (cfg_calendar_switch_day)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Floor division for a positive divisor.
  function automatic longint floor_quot(input longint a, input longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q--;
    return q;
  endfunction

  // Date of one day number under the given switch day.
  function automatic date_t day_to_date(input day_num_t jdn, input day_num_t sw);
    longint jd, y, s, t, m, d;
    bit     greg;
    date_t  r;
    jd   = longint'(jdn);
    greg = (jdn >= sw);
    if (greg) y = floor_quot((jd - GREG_EPOCH) * 10000, GREG_YEAR);
    else      y = floor_quot((jd - JUL_EPOCH) * 4, 1461);
    s = YEAR_BASE + floor_quot(1461 * y, 4);
    // century correction truncates toward zero, like plain integer division
    if (greg) s += 2 + y / 400 - y / 100;
    t = jd - s;
    m = floor_quot(t * 10000, MONTH_LEN);
    d = t - floor_quot(MONTH_LEN * m, 10000);
    // March-based month back to January-based; Jan/Feb roll into next year
    m--;
    if (m > 12) m -= 12;
    if (m <= 2) y++;
    if (y <= 0) y--;  // no year zero
    if (y < YEAR_LO || y > YEAR_HI || m < 1 || m > 12 || d < 1 || d > 31) begin
      r = BAD_DATE;
    end else begin
      r.day   = 5'(d);
      r.month = 4'(m);
      r.year  = 15'(y);
      r.err   = 1'b0;
    end
    return r;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Random day number, weighted toward the places where the date logic turns.
  function automatic day_num_t pick_day(input day_num_t sw);
    longint c, w, v;
    int     r;
    r = $urandom_range(0, 9);
    w = 400;
    case (r)
      5: c = longint'(sw);
      6: c = longint'(DAY_TOP);
      7: return day_num_t'($urandom);
      8: c = 400;
      9: c = 1721424;            // around 1 Jan AD 1
      default: return day_num_t'($urandom_range(0, DAY_TOP));
    endcase
    v = c + longint'($urandom_range(0, 2 * w)) - w;
    if (v < 0) v = 0;
    if (v > 23'h7FFFFF) v = 23'h7FFFFF;
    return day_num_t'(v);
  endfunction

  // Offer one request and hold it until the block takes it. Returns at the
  // falling edge after acceptance with in_valid still high.
  task automatic send_request(input day_num_t jd, input logic typed, input date_t want);
    in_valid      <= 1'b1;
    in_day_number <= jd;
    row_typed     <= typed;
    row_want      <= want;
    do @(negedge clk); while (!in_acc);
  endtask

  // Optional idle gap on the request side after an accepted request.
  task automatic pace(input bit burst);
    int g;
    g = burst ? 0 : gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  // Stop offering and wait until every expected date has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (dates_due.size() != 0) @(negedge clk);
  endtask

  // Register write; only called with the pipeline empty.
  task automatic write_switch(input day_num_t v);
    cfg_valid               <= 1'b1;
    cfg_calendar_switch_day <= v;
    do @(negedge clk); while (!cfg_acc);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Monitor and checker: everything sampled at the rising edge. Accepted
  // requests are turned into expected dates here, results are compared in
  // order, and the watchdog counts edges with no handshake anywhere.
  always @(posedge clk) begin
    bit    out_acc;
    date_t got;
    date_t want;
    out_acc = 1'b0;
    in_acc  = 1'b0;
    cfg_acc = 1'b0;
    if (rst_n === 1'b1) begin
      in_acc  = (in_valid === 1'b1) && (in_ready === 1'b1);
      cfg_acc = (cfg_valid === 1'b1) && (cfg_ready === 1'b1);
      out_acc = (out_valid === 1'b1) && (out_ready === 1'b1);
      if (cfg_acc) switch_day = cfg_calendar_switch_day;
      if (in_acc) begin
        if (row_typed) dates_due.push_back(row_want);
        else           dates_due.push_back(day_to_date(in_day_number, switch_day));
      end
      if (out_acc) begin
        dates_seen++;
        got = '{out_day_of_month, out_month_of_year, out_year_value, out_range_error};
        if (dates_due.size() == 0) begin
          $error("unexpected result: day %0d month %0d year %0d range_error %0d",
                 got.day, got.month, got.year, got.err);
          err_cnt++;
        end else begin
          want = dates_due.pop_front();
          if (got.day !== want.day) begin
            $error("day_of_month: expected %0d, got %0d", want.day, got.day);
            err_cnt++;
          end
          if (got.month !== want.month) begin
            $error("month_of_year: expected %0d, got %0d", want.month, got.month);
            err_cnt++;
          end
          if (got.year !== want.year) begin
            $error("year_value: expected %0d, got %0d", want.year, got.year);
            err_cnt++;
          end
          if (got.err !== want.err) begin
            $error("range_error: expected %0d, got %0d", want.err, got.err);
            err_cnt++;
          end
        end
      end
      if (in_acc || cfg_acc || out_acc) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Result side: random ready/stall runs, with two long hold-offs that let
  // the pipeline fill and push back on incoming requests.
  initial begin
    int run;
    int stall;
    bit held_a;
    bit held_b;
    held_a    = 1'b0;
    held_b    = 1'b0;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      out_ready <= 1'b1;
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 6);
      repeat (run) @(negedge clk);
      if (!held_a && dates_seen >= 200) begin
        held_a = 1'b1;
        stall  = LONG_HOLD;
      end else if (!held_b && dates_seen >= 900) begin
        held_b = 1'b1;
        stall  = LONG_HOLD;
      end else begin
        stall = gap_len();
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
    end
  end

  // Request side: directed table, then random phases, each phase under its
  // own switch day.
  initial begin
    day_num_t sw;
    bit       burst;
    in_valid                = 1'b0;
    in_day_number           = '0;
    cfg_valid               = 1'b0;
    cfg_calendar_switch_day = '0;
    row_typed               = 1'b0;
    row_want                = NO_DATE;
    rst_n                   = 1'b0;

    // Typed rows: reset switch day on both sides, the first and last
    // representable days, and out-of-range years.
    dir_tab = '{
      '{ROW_REQ, 23'd2361222, 1'b1, '{5'd14, 4'd9,  15'sd1752,  1'b0}},
      '{ROW_REQ, 23'd2361221, 1'b1, '{5'd2,  4'd9,  15'sd1752,  1'b0}},
      '{ROW_REQ, 23'd0,       1'b1, '{5'd1,  4'd1,  -15'sd4713, 1'b0}},
      '{ROW_REQ, 23'd5373484, 1'b1, '{5'd31, 4'd12, 15'sd9999,  1'b0}},
      '{ROW_REQ, 23'd5373485, 1'b1, BAD_DATE},
      '{ROW_REQ, 23'd8388607, 1'b1, BAD_DATE},
      // around year 1 and a few Gregorian leap rules
      '{ROW_REQ, 23'd1721424, 1'b0, NO_DATE},
      '{ROW_REQ, 23'd1721423, 1'b0, NO_DATE},
      '{ROW_REQ, 23'd2299160, 1'b0, NO_DATE},
      '{ROW_REQ, 23'd2451545, 1'b0, NO_DATE},
      '{ROW_REQ, 23'd2415080, 1'b0, NO_DATE},
      '{ROW_REQ, 23'd4194304, 1'b0, NO_DATE},
      // everything Gregorian: negative years can give inconsistent dates
      '{ROW_CFG, 23'd0,       1'b0, NO_DATE},
      '{ROW_REQ, 23'd0,       1'b0, NO_DATE},
      '{ROW_REQ, 23'd60000,   1'b0, NO_DATE},
      '{ROW_REQ, 23'd1000000, 1'b0, NO_DATE},
      // everything Julian, switch day beyond the day range
      '{ROW_CFG, 23'd8388607, 1'b0, NO_DATE},
      '{ROW_REQ, 23'd5373484, 1'b0, NO_DATE},
      '{ROW_REQ, 23'd2361222, 1'b0, NO_DATE},
      '{ROW_CFG, 23'd5373484, 1'b0, NO_DATE},
      '{ROW_REQ, 23'd5373483, 1'b0, NO_DATE},
      '{ROW_REQ, 23'd5373484, 1'b0, NO_DATE},
      '{ROW_CFG, 23'd2361222, 1'b0, NO_DATE},
      '{ROW_REQ, 23'd2361222, 1'b1, '{5'd14, 4'd9,  15'sd1752,  1'b0}}
    };

    repeat (RST_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        drain();
        write_switch(dir_tab[i].val);
      end else begin
        send_request(dir_tab[i].val, dir_tab[i].typed, dir_tab[i].want);
        pace(1'b0);
      end
    end

    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        1:       sw = 23'd0;
        2:       sw = DAY_TOP;
        3:       sw = 23'h7FFFFF;
        4:       sw = 23'd2299161;
        5:       sw = day_num_t'($urandom);
        6:       sw = 23'd1721424;
        default: sw = day_num_t'($urandom_range(0, DAY_TOP));
      endcase
      burst = (p == 3 || p == 7);  // back-to-back requests, no gaps
      drain();
      write_switch(sw);
      for (int k = 0; k < PHASE_REQS; k++) begin
        send_request(pick_day(sw), 1'b0, NO_DATE);
        pace(burst);
      end
    end

    drain();
    repeat (DRAIN_WAIT) @(negedge clk);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
